/* rtl/core/dmxr_pkg.sv */
// Shared types and constants for the DMX512 break/MAB receiver core.
// It has no dependencies. The front, back and top modules import it.
package dmxr_pkg;

  localparam int MAX_SLOTS  = 512;
  localparam int SLOT_DEPTH = MAX_SLOTS + 1;
  localparam int IDX_W      = $clog2(SLOT_DEPTH + 1);
  localparam int TS_W       = 32;
  localparam int TICK_W     = 24;
  localparam int CMD_W      = 3;
  localparam int STATUS_W   = 4;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CMD_W-1:0] CMD_FRAME_ERR = 3'd0;
  localparam logic [CMD_W-1:0] CMD_RISE      = 3'd1;
  localparam logic [CMD_W-1:0] CMD_FALL      = 3'd2;
  localparam logic [CMD_W-1:0] CMD_BYTE      = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ      = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_BREAK_MIN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAB_MIN    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PACKET_MIN = 2'd2;

  localparam logic [TICK_W-1:0] BREAK_MIN_RESET  = 24'd2000;
  localparam logic [TICK_W-1:0] MAB_MIN_RESET    = 24'd200;
  localparam logic [TICK_W-1:0] PACKET_MIN_RESET = 24'd50000;

  localparam logic [7:0] START_CODE = 8'h00;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_FRAME_ERR,
    OP_RISE,
    OP_FALL,
    OP_BYTE,
    OP_READ
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_IGNORED        = 4'd0,
    ST_BREAK_OK       = 4'd1,
    ST_BREAK_SHORT    = 4'd2,
    ST_MAB_OK         = 4'd3,
    ST_MAB_SHORT      = 4'd4,
    ST_SLOT_STORED    = 4'd5,
    ST_BAD_START      = 4'd6,
    ST_OVERRUN        = 4'd7,
    ST_PACKET_READY   = 4'd8,
    ST_PACKET_DISCARD = 4'd9
  } status_t;

  // One classified event as it waits in the queue.
  typedef struct packed {
    op_t              op;
    logic [TS_W-1:0]  timestamp;
    logic [7:0]       rx_byte;
    logic [IDX_W-1:0] slot_index;
    logic             read_ok;
  } event_t;

endpackage

/* rtl/core/dmxr_front.sv */
// Front end of the receiver core: accepts event words, decodes the command
// and holds them in a two-entry queue. Depends on dmxr_pkg.
module dmxr_front
  import dmxr_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [CMD_W-1:0] cmd,
  input  logic [TS_W-1:0]  timestamp,
  input  logic [7:0]       rx_byte,
  input  logic [IDX_W-1:0] slot_index,
  output logic             q_valid,
  output event_t           q_head,
  input  logic             q_pop
);

  event_t     queue [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  event_t     decoded;

  always_comb begin
    decoded.timestamp  = timestamp;
    decoded.rx_byte    = rx_byte;
    decoded.slot_index = slot_index;
    decoded.read_ok    = (slot_index <= IDX_W'(MAX_SLOTS));
    unique case (cmd)
      CMD_FRAME_ERR: decoded.op = OP_FRAME_ERR;
      CMD_RISE:      decoded.op = OP_RISE;
      CMD_FALL:      decoded.op = OP_FALL;
      CMD_BYTE:      decoded.op = OP_BYTE;
      CMD_READ:      decoded.op = OP_READ;
      default:       decoded.op = OP_NONE;
    endcase
  end

  assign in_ready = (count != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != 2'd0);
  assign q_head   = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, q_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/core/dmxr_back.sv */
// Back end of the receiver core: timing checks, framing state, slot buffer
// and the result register. Also holds the configuration registers.
// Depends on dmxr_pkg.
module dmxr_back
  import dmxr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  input  event_t               q_head,
  output logic                 q_pop,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TICK_W-1:0]    cfg_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [STATUS_W-1:0]  status,
  output logic                 packet_ready,
  output logic [IDX_W-1:0]     packet_length,
  output logic [7:0]           slot_data
);

  logic [TICK_W-1:0] break_min_ticks;
  logic [TICK_W-1:0] mab_min_ticks;
  logic [TICK_W-1:0] packet_min_ticks;

  logic seen_first_break, seen_first_break_next;
  logic break_valid, break_valid_next;
  logic mab_valid, mab_valid_next;
  logic data_corrupt, data_corrupt_next;
  logic rise_armed, rise_armed_next;
  logic fall_armed, fall_armed_next;
  logic [TS_W-1:0] break_start_time, break_start_time_next;
  logic [TS_W-1:0] next_break_start_time, next_break_start_time_next;
  logic [TS_W-1:0] mab_start_time, mab_start_time_next;
  logic [IDX_W-1:0] slot_count, slot_count_next;
  logic [IDX_W-1:0] saved_length, saved_length_next;

  status_t          status_reg, status_next;
  logic             packet_ready_reg, packet_ready_next;
  logic [IDX_W-1:0] packet_length_reg, packet_length_next;
  logic             read_sel;
  logic [7:0]       read_data;

  logic [7:0] slot_mem [SLOT_DEPTH];
  logic       wr_en;
  logic       rd_en;

  logic [TS_W-1:0] first_span;
  logic [TS_W-1:0] later_span;
  logic [TS_W-1:0] packet_span;
  logic [TS_W-1:0] mab_span;
  logic            advance;

  assign cfg_ready = 1'b1;
  assign advance   = !out_valid || out_ready;
  assign q_pop     = q_valid && advance;

  // The four spans are independent subtractions taken in parallel.
  assign first_span  = q_head.timestamp - break_start_time;
  assign later_span  = q_head.timestamp - next_break_start_time;
  assign packet_span = next_break_start_time - break_start_time;
  assign mab_span    = q_head.timestamp - mab_start_time;

  always_comb begin
    seen_first_break_next      = seen_first_break;
    break_valid_next           = break_valid;
    mab_valid_next             = mab_valid;
    data_corrupt_next          = data_corrupt;
    rise_armed_next            = rise_armed;
    fall_armed_next            = fall_armed;
    break_start_time_next      = break_start_time;
    next_break_start_time_next = next_break_start_time;
    mab_start_time_next        = mab_start_time;
    slot_count_next            = slot_count;
    saved_length_next          = saved_length;
    status_next                = ST_IGNORED;
    packet_ready_next          = 1'b0;
    packet_length_next         = '0;
    wr_en                      = 1'b0;
    rd_en                      = 1'b0;
    unique case (q_head.op)
      OP_FRAME_ERR: begin
        if (!break_valid && !mab_valid) begin
          break_start_time_next = q_head.timestamp;
        end else if (mab_valid) begin
          next_break_start_time_next = q_head.timestamp;
        end
        if (!break_valid || mab_valid) begin
          saved_length_next = slot_count;
          slot_count_next   = '0;
          rise_armed_next   = 1'b1;
        end
      end
      OP_RISE: begin
        if (rise_armed) begin
          rise_armed_next     = 1'b0;
          mab_start_time_next = q_head.timestamp;
          if (!seen_first_break) begin
            if (first_span > TS_W'(break_min_ticks)) begin
              break_valid_next      = 1'b1;
              seen_first_break_next = 1'b1;
              fall_armed_next       = 1'b1;
              data_corrupt_next     = 1'b0;
              status_next           = ST_BREAK_OK;
            end else begin
              status_next = ST_BREAK_SHORT;
            end
          end else if (later_span <= TS_W'(break_min_ticks)) begin
            data_corrupt_next = 1'b1;
            saved_length_next = '0;
            status_next       = ST_BREAK_SHORT;
          end else begin
            fall_armed_next       = 1'b1;
            mab_valid_next        = 1'b0;
            break_valid_next      = 1'b1;
            seen_first_break_next = 1'b1;
            data_corrupt_next     = 1'b0;
            break_start_time_next = next_break_start_time;
            if (packet_span < TS_W'(packet_min_ticks)) begin
              saved_length_next = '0;
              status_next       = ST_PACKET_DISCARD;
            end else begin
              packet_ready_next  = 1'b1;
              packet_length_next = saved_length;
              status_next        = ST_PACKET_READY;
            end
          end
        end
      end
      OP_FALL: begin
        if (fall_armed) begin
          fall_armed_next = 1'b0;
          if (break_valid) begin
            break_valid_next = 1'b0;
            if (mab_span > TS_W'(mab_min_ticks)) begin
              mab_valid_next = 1'b1;
              status_next    = ST_MAB_OK;
            end else begin
              seen_first_break_next = 1'b0;
              status_next           = ST_MAB_SHORT;
            end
          end
        end
      end
      OP_BYTE: begin
        if (mab_valid && !data_corrupt) begin
          if (slot_count == '0 && q_head.rx_byte != START_CODE) begin
            mab_valid_next        = 1'b0;
            seen_first_break_next = 1'b0;
            status_next           = ST_BAD_START;
          end else if (slot_count > IDX_W'(MAX_SLOTS)) begin
            slot_count_next = '0;
            status_next     = ST_OVERRUN;
          end else begin
            wr_en           = 1'b1;
            slot_count_next = slot_count + 1'b1;
            status_next     = ST_SLOT_STORED;
          end
        end
      end
      OP_READ: begin
        rd_en = q_head.read_ok;
      end
      default: begin
      end
    endcase
  end

  // Slot buffer: one write port at the slot count, one registered read port.
  always_ff @(posedge clk) begin
    if (q_pop && wr_en) begin
      slot_mem[slot_count] <= q_head.rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && rd_en) begin
      read_data <= slot_mem[q_head.slot_index];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      status_reg        <= status_next;
      packet_ready_reg  <= packet_ready_next;
      packet_length_reg <= packet_length_next;
      read_sel          <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid             <= 1'b0;
      break_min_ticks       <= BREAK_MIN_RESET;
      mab_min_ticks         <= MAB_MIN_RESET;
      packet_min_ticks      <= PACKET_MIN_RESET;
      seen_first_break      <= 1'b0;
      break_valid           <= 1'b0;
      mab_valid             <= 1'b0;
      data_corrupt          <= 1'b0;
      rise_armed            <= 1'b0;
      fall_armed            <= 1'b0;
      break_start_time      <= '0;
      next_break_start_time <= '0;
      mab_start_time        <= '0;
      slot_count            <= '0;
      saved_length          <= '0;
    end else begin
      if (advance) begin
        out_valid <= q_valid;
      end
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_BREAK_MIN:  break_min_ticks  <= cfg_data;
          REG_MAB_MIN:    mab_min_ticks    <= cfg_data;
          REG_PACKET_MIN: packet_min_ticks <= cfg_data;
          default: begin
          end
        endcase
      end
      if (q_pop) begin
        seen_first_break      <= seen_first_break_next;
        break_valid           <= break_valid_next;
        mab_valid             <= mab_valid_next;
        data_corrupt          <= data_corrupt_next;
        rise_armed            <= rise_armed_next;
        fall_armed            <= fall_armed_next;
        break_start_time      <= break_start_time_next;
        next_break_start_time <= next_break_start_time_next;
        mab_start_time        <= mab_start_time_next;
        slot_count            <= slot_count_next;
        saved_length          <= saved_length_next;
      end
    end
  end

  assign status        = status_reg;
  assign packet_ready  = packet_ready_reg;
  assign packet_length = packet_length_reg;
  assign slot_data     = read_sel ? read_data : 8'd0;

endmodule

/* rtl/core/dmx512_break_mab_receiver_core.sv */
// DMX512 break/MAB receiver core. An accepted word is registered in the queue
// and then in the result register before it is answered. Throughput: one word
// per cycle while the answer side is not stalled.
// Reset clears framing state, queue and result valid flag and loads the timing
// minimums with their defaults; the slot buffer is not cleared.
module dmx512_break_mab_receiver_core
  import dmxr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [CMD_W-1:0]     cmd,
  input  logic [TS_W-1:0]      timestamp,
  input  logic [7:0]           rx_byte,
  input  logic [IDX_W-1:0]     slot_index,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [STATUS_W-1:0]  status,
  output logic                 packet_ready,
  output logic [IDX_W-1:0]     packet_length,
  output logic [7:0]           slot_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TICK_W-1:0]    cfg_data
);

  // The front end decodes each incoming word and parks it in a two-entry
  // queue, so the input side keeps flowing while a result waits downstream.
  event_t q_head;
  logic   q_valid;
  logic   q_pop;

  dmxr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .timestamp  (timestamp),
    .rx_byte    (rx_byte),
    .slot_index (slot_index),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop)
  );

  // The back end pops one word per cycle whenever its result register is
  // free or being drained, runs the break, MAB and packet timing checks,
  // and reads or writes the slot buffer.
  dmxr_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .packet_ready  (packet_ready),
    .packet_length (packet_length),
    .slot_data     (slot_data)
  );

  // A packet is flagged ready only together with its status code.
  a_ready_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && packet_ready |-> status == ST_PACKET_READY)
    else $error("packet_ready without packet-ready status");

  // A length is reported only with a ready packet.
  a_length_ready: assert property (@(posedge clk) disable iff (rst)
    out_valid && packet_length != '0 |-> packet_ready)
    else $error("packet_length without packet_ready");

  // Slot data comes back only for reads, which carry no verdict.
  a_data_read: assert property (@(posedge clk) disable iff (rst)
    out_valid && slot_data != 8'd0 |-> status == ST_IGNORED)
    else $error("slot_data on a non-read word");

  // A word is popped only when the queue has one and the result register has room.
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid && (!out_valid || out_ready))
    else $error("queue popped without a word or room");

endmodule

/* verif/dmx512_break_mab_receiver_core_tb.sv */
// Self-checking testbench for the DMX512 break/MAB receiver core.
// It depends only on dmxr_pkg and the core RTL. It predicts every answer
// word in-line and compares the answers field by field.
`timescale 1ns / 1ps

module dmx512_break_mab_receiver_core_tb;
  import dmxr_pkg::*;

  // Command codes that the core must ignore, and the register index with no
  // register behind it.
  localparam logic [CMD_W-1:0]     CMD_SPARE_LO = 3'd5;
  localparam logic [CMD_W-1:0]     CMD_SPARE_HI = 3'd7;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE    = 2'd3;
  localparam int                   IDLE_MAX     = 17;

  // One event word as the generator queues it. When pick is set on a slot
  // read, the driver chooses the index at send time from the slots that really
  // hold data or past the buffer, so a never-written entry is never read.
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [TS_W-1:0]  ts;
    logic [7:0]       data;
    logic [IDX_W-1:0] idx;
    logic             pick;
  } dmx_event_t;

  typedef struct packed {
    status_t          status;
    logic             ready;
    logic [IDX_W-1:0] length;
    logic [7:0]       data;
  } verdict_t;

  typedef enum {FLAW_NONE, FLAW_SHORT_BREAK, FLAW_SHORT_MARK, FLAW_BAD_START,
                FLAW_SHORT_PERIOD} flaw_t;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [CMD_W-1:0]     cmd = '0;
  logic [TS_W-1:0]      timestamp = '0;
  logic [7:0]           rx_byte = '0;
  logic [IDX_W-1:0]     slot_index = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [STATUS_W-1:0]  status;
  logic                 packet_ready;
  logic [IDX_W-1:0]     packet_length;
  logic [7:0]           slot_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [TICK_W-1:0]    cfg_data = '0;

  dmx512_break_mab_receiver_core u_top (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run (about seven hundred words,
  // each with the longest send gap and answer stall).
  initial begin
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Framer prediction. This is our own copy of the timing limits and of the
  // receive state; it is advanced once per accepted event word.
  // ---------------------------------------------------------------------------
  logic [31:0] brk_min = {8'd0, BREAK_MIN_RESET};
  logic [31:0] mab_min = {8'd0, MAB_MIN_RESET};
  logic [31:0] pkt_min = {8'd0, PACKET_MIN_RESET};

  bit          synced     = 1'b0;  // a first good break has been seen
  bit          break_good = 1'b0;  // break accepted, waiting for the MAB end
  bit          mark_good  = 1'b0;  // MAB accepted, slots may be stored
  bit          tainted    = 1'b0;  // a short later break spoiled the data
  bit          want_rise  = 1'b0;
  bit          want_fall  = 1'b0;
  logic [31:0] brk_t0     = '0;    // start of the break that opened the packet
  logic [31:0] brk_t1     = '0;    // start of the break that closes it
  logic [31:0] mark_t0    = '0;
  int          slot_cnt   = 0;
  int          held_len   = 0;
  int          slots_filled = 0;   // slots 0 .. slots_filled-1 have been written
  logic [7:0]  shadow_slots [0:MAX_SLOTS];

  function automatic verdict_t framer_step(input dmx_event_t ev);
    verdict_t v;
    logic [31:0] span;
    bit took;
    v.status = ST_IGNORED;
    v.ready  = 1'b0;
    v.length = '0;
    v.data   = '0;
    took     = 1'b0;
    case (ev.cmd)
      CMD_FRAME_ERR: begin
        // A frame error opens a break. With a packet in progress it marks
        // the end of that packet; between a good break and its MAB it is
        // simply ignored. The status is always "ignored".
        if (!break_good && !mark_good) begin
          brk_t0 = ev.ts;
          took = 1'b1;
        end else if (mark_good) begin
          brk_t1 = ev.ts;
          took = 1'b1;
        end
        if (took) begin
          held_len = slot_cnt;
          slot_cnt = 0;
          want_rise = 1'b1;
        end
      end
      CMD_RISE: if (want_rise) begin
        want_rise = 1'b0;
        mark_t0 = ev.ts;
        if (!synced) begin
          span = ev.ts - brk_t0;
          if (span > brk_min) begin
            break_good = 1'b1;
            synced = 1'b1;
            want_fall = 1'b1;
            tainted = 1'b0;
            v.status = ST_BREAK_OK;
          end else begin
            v.status = ST_BREAK_SHORT;
          end
        end else begin
          span = ev.ts - brk_t1;
          if (span <= brk_min) begin
            // A short break inside a running stream keeps the MAB state but
            // spoils the packet until the next good break.
            tainted = 1'b1;
            held_len = 0;
            v.status = ST_BREAK_SHORT;
          end else begin
            want_fall = 1'b1;
            mark_good = 1'b0;
            break_good = 1'b1;
            synced = 1'b1;
            tainted = 1'b0;
            span = brk_t1 - brk_t0;
            brk_t0 = brk_t1;
            if (span < pkt_min) begin
              held_len = 0;
              v.status = ST_PACKET_DISCARD;
            end else begin
              v.status = ST_PACKET_READY;
              v.ready = 1'b1;
              v.length = IDX_W'(held_len);
            end
          end
        end
      end
      CMD_FALL: if (want_fall) begin
        want_fall = 1'b0;
        span = ev.ts - mark_t0;
        if (break_good) begin
          break_good = 1'b0;
          if (span > mab_min) begin
            mark_good = 1'b1;
            v.status = ST_MAB_OK;
          end else begin
            synced = 1'b0;
            v.status = ST_MAB_SHORT;
          end
        end
      end
      CMD_BYTE: if (mark_good && !tainted) begin
        if (slot_cnt == 0 && ev.data != START_CODE) begin
          mark_good = 1'b0;
          synced = 1'b0;
          v.status = ST_BAD_START;
        end else if (slot_cnt > MAX_SLOTS) begin
          slot_cnt = 0;
          v.status = ST_OVERRUN;
        end else begin
          shadow_slots[slot_cnt] = ev.data;
          slot_cnt++;
          if (slot_cnt > slots_filled) slots_filled = slot_cnt;
          v.status = ST_SLOT_STORED;
        end
      end
      CMD_READ: begin
        if (int'(ev.idx) <= MAX_SLOTS) v.data = shadow_slots[ev.idx];
      end
      default: ;
    endcase
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Event driver. Words wait in events_to_send; each accepted word is run
  // through the predictor and its answer joins verdicts_due. Before every
  // word the driver idles for a random number of cycles, except in calm
  // stretches where it sends back to back.
  // ---------------------------------------------------------------------------
  dmx_event_t events_to_send[$];
  verdict_t   verdicts_due[$];
  dmx_event_t on_wire;
  bit         wire_busy = 1'b0;
  bit         send_calm = 1'b0;
  int         send_wait = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      wire_busy = 1'b0;
      send_wait = 0;
    end else begin
      if (in_valid && in_ready) begin
        verdicts_due.push_back(framer_step(on_wire));
        wire_busy = 1'b0;
        if ($urandom_range(0, 31) == 0) send_calm = !send_calm;
        send_wait = send_calm ? 0 : $urandom_range(0, IDLE_MAX);
      end
      if (!wire_busy && send_wait > 0) begin
        send_wait--;
      end else if (!wire_busy && events_to_send.size() != 0) begin
        on_wire = events_to_send.pop_front();
        if (on_wire.cmd == CMD_READ && on_wire.pick) begin
          // Read a written slot most of the time, now and then the highest
          // one written, and sometimes an index past the buffer.
          if (slots_filled == 0 || $urandom_range(0, 7) == 0)
            on_wire.idx = IDX_W'($urandom_range(MAX_SLOTS + 1, 1023));
          else if ($urandom_range(0, 9) == 0)
            on_wire.idx = IDX_W'(slots_filled - 1);
          else
            on_wire.idx = IDX_W'($urandom_range(0, slots_filled - 1));
        end
        cmd        <= on_wire.cmd;
        timestamp  <= on_wire.ts;
        rx_byte    <= on_wire.data;
        slot_index <= on_wire.idx;
        wire_busy = 1'b1;
      end
      in_valid <= wire_busy;
    end
  end

  // ---------------------------------------------------------------------------
  // Answer monitor. Each accepted answer word is checked against the oldest
  // prediction. After every answer the ready line drops for a random number
  // of cycles, again with calm stretches of no stalling.
  // ---------------------------------------------------------------------------
  int       mismatches = 0;
  verdict_t oldest;
  bit       recv_calm = 1'b0;
  int       recv_wait = 0;

  function automatic void check_field(input string name, input logic [31:0] want_v,
                                      input logic [31:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t ns: %s expected %0d, got %0d", $time, name, want_v, got_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      recv_wait = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (verdicts_due.size() == 0) begin
          $display("%0t ns: answer expected none, got status %0d", $time, status);
          mismatches++;
        end else begin
          oldest = verdicts_due.pop_front();
          check_field("status", oldest.status, status);
          check_field("packet_ready", oldest.ready, packet_ready);
          check_field("packet_length", oldest.length, packet_length);
          check_field("slot_data", oldest.data, slot_data);
        end
        if ($urandom_range(0, 31) == 0) recv_calm = !recv_calm;
        recv_wait = recv_calm ? 0 : $urandom_range(0, IDLE_MAX);
      end
      if (recv_wait > 0) begin
        recv_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus.
  // ---------------------------------------------------------------------------
  logic [31:0] now_ts;  // tick count where the generator's next break begins

  task automatic queue_event(input logic [CMD_W-1:0] c, input logic [TS_W-1:0] t,
                             input logic [7:0] b, input logic [IDX_W-1:0] i,
                             input logic pick);
    dmx_event_t e;
    e = '{cmd: c, ts: t, data: b, idx: i, pick: pick};
    events_to_send.push_back(e);
  endtask

  // A span that passes or fails a minimum, landing right on the boundary
  // about a quarter of the time. Break and MAB lengths must strictly exceed
  // their minimum; the packet period only has to reach it.
  function automatic logic [31:0] span_for(input logic [31:0] lim, input bit pass,
                                           input bit strict);
    logic [31:0] brink;
    if (pass) begin
      brink = lim + (strict ? 32'd1 : 32'd0);
      return ($urandom_range(0, 3) == 0) ? brink : brink + $urandom_range(0, 3000);
    end
    brink = (strict || lim == 0) ? lim : lim - 1;
    return ($urandom_range(0, 3) == 0) ? brink : $urandom_range(0, brink);
  endfunction

  // One packet as it would appear on the line: break, MAB, start code and
  // slots, with slot reads mixed in when asked for. A flaw spoils one part.
  task automatic send_packet(input int n_slots, input flaw_t flaw, input bit with_reads);
    logic [31:0] t0, t;
    int k;
    t0 = now_ts;
    queue_event(CMD_FRAME_ERR, t0, 8'($urandom), IDX_W'($urandom), 1'b0);
    t = t0 + span_for(brk_min, flaw != FLAW_SHORT_BREAK, 1'b1);
    queue_event(CMD_RISE, t, 8'($urandom), IDX_W'($urandom), 1'b0);
    t = t + span_for(mab_min, flaw != FLAW_SHORT_MARK, 1'b1);
    queue_event(CMD_FALL, t, 8'($urandom), IDX_W'($urandom), 1'b0);
    queue_event(CMD_BYTE, $urandom,
                (flaw == FLAW_BAD_START) ? 8'($urandom_range(1, 255)) : START_CODE,
                IDX_W'($urandom), 1'b0);
    for (k = 0; k < n_slots; k++) begin
      queue_event(CMD_BYTE, $urandom, 8'($urandom), IDX_W'($urandom), 1'b0);
      if (with_reads && $urandom_range(0, 5) == 0)
        queue_event(CMD_READ, $urandom, 8'($urandom), '0, 1'b1);
    end
    now_ts = t0 + span_for(pkt_min, flaw != FLAW_SHORT_PERIOD, 1'b0);
  endtask

  // Mostly well-formed packets with random content; the rest are flawed
  // packets and single random words (unknown commands among them).
  task automatic run_phase(input int budget);
    int roll, n;
    while (budget > 0) begin
      roll = $urandom_range(0, 99);
      if (roll < 15) begin
        queue_event(CMD_W'($urandom_range(0, 7)), $urandom, 8'($urandom),
                    IDX_W'($urandom_range(0, 1023)), 1'b1);
        budget--;
      end else begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
        send_packet(n, (roll < 70) ? FLAW_NONE : flaw_t'($urandom_range(1, 4)), 1'b1);
        budget -= n + 4;
      end
    end
  endtask

  // Every event word gets exactly one answer, so an empty prediction queue
  // means the core is idle; a few extra cycles are added on top of that.
  task automatic drain_framer();
    while (events_to_send.size() != 0 || wire_busy || verdicts_due.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TICK_W-1:0] val);
    @(posedge clk);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_BREAK_MIN:  brk_min = {8'd0, val};
      REG_MAB_MIN:    mab_min = {8'd0, val};
      REG_PACKET_MIN: pkt_min = {8'd0, val};
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic load_limits(input logic [TICK_W-1:0] b, input logic [TICK_W-1:0] m,
                             input logic [TICK_W-1:0] p);
    drain_framer();
    write_reg(REG_BREAK_MIN, b);
    write_reg(REG_MAB_MIN, m);
    write_reg(REG_PACKET_MIN, p);
  endtask

  logic [31:0] ta;

  initial begin
    now_ts = $urandom;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed part, at the reset limits (break 2000, MAB 200, period 50000).
    // Nothing is armed yet: an out-of-range read, a lone rise, a lone fall and
    // a byte before any MAB all answer "ignored".
    queue_event(CMD_READ, $urandom, 8'hFF, 10'h3FF, 1'b0);
    queue_event(CMD_RISE, $urandom, 8'h00, '0, 1'b0);
    queue_event(CMD_FALL, $urandom, 8'h00, '0, 1'b0);
    queue_event(CMD_BYTE, $urandom, START_CODE, '0, 1'b0);
    queue_event(CMD_SPARE_HI, 32'hFFFF_FFFF, 8'hFF, 10'h3FF, 1'b0);

    // First break exactly at the minimum is short.
    ta = 32'hFFFF_F000;
    queue_event(CMD_FRAME_ERR, ta, 8'h00, '0, 1'b0);
    queue_event(CMD_RISE, ta + 32'd2000, 8'h00, '0, 1'b0);

    // One tick longer passes, across the timestamp wrap. A frame error
    // between the good break and its MAB does nothing; a MAB of exactly the
    // minimum is short and drops sync.
    ta = 32'hFFFF_FC00;
    queue_event(CMD_FRAME_ERR, ta, 8'h00, '0, 1'b0);
    queue_event(CMD_RISE, ta + 32'd2001, 8'h00, '0, 1'b0);
    queue_event(CMD_FRAME_ERR, ta + 32'd2100, 8'h00, '0, 1'b0);
    queue_event(CMD_FALL, ta + 32'd2201, 8'h00, '0, 1'b0);

    // Clean break and MAB, a short packet, then a period one tick too short:
    // the packet is discarded. The following packet has a bad start code.
    ta = 32'h0001_0000;
    queue_event(CMD_FRAME_ERR, ta, 8'h00, '0, 1'b0);
    queue_event(CMD_RISE, ta + 32'd5000, 8'h00, '0, 1'b0);
    queue_event(CMD_FALL, ta + 32'd5201, 8'h00, '0, 1'b0);
    queue_event(CMD_BYTE, $urandom, START_CODE, '0, 1'b0);
    queue_event(CMD_BYTE, $urandom, 8'hFF, '0, 1'b0);
    queue_event(CMD_READ, $urandom, 8'h00, 10'd1, 1'b0);
    queue_event(CMD_FRAME_ERR, ta + 32'd49999, 8'h00, '0, 1'b0);
    queue_event(CMD_RISE, ta + 32'd52000, 8'h00, '0, 1'b0);
    queue_event(CMD_FALL, ta + 32'd52500, 8'h00, '0, 1'b0);
    queue_event(CMD_BYTE, $urandom, 8'h80, '0, 1'b0);

    // Resync, then a short break inside the stream spoils the data so the
    // next byte is ignored; the following good break reports the packet
    // ready with length zero and clears the spoiled state.
    ta = 32'h8000_0000;
    queue_event(CMD_FRAME_ERR, ta, 8'h00, '0, 1'b0);
    queue_event(CMD_RISE, ta + 32'd2500, 8'h00, '0, 1'b0);
    queue_event(CMD_FALL, ta + 32'd2800, 8'h00, '0, 1'b0);
    queue_event(CMD_BYTE, $urandom, START_CODE, '0, 1'b0);
    queue_event(CMD_FRAME_ERR, ta + 32'd50000, 8'h00, '0, 1'b0);
    queue_event(CMD_RISE, ta + 32'd50100, 8'h00, '0, 1'b0);
    queue_event(CMD_BYTE, $urandom, START_CODE, '0, 1'b0);
    queue_event(CMD_FRAME_ERR, ta + 32'd60000, 8'h00, '0, 1'b0);
    queue_event(CMD_RISE, ta + 32'd63000, 8'h00, '0, 1'b0);
    queue_event(CMD_SPARE_LO, $urandom, 8'h00, '0, 1'b0);

    // Random part at the reset limits, including one packet long enough to
    // fill every slot and overrun the buffer. That packet carries no reads;
    // later phases read its slots back.
    now_ts = ta + 32'd200000;
    run_phase(15);
    send_packet(MAX_SLOTS + 2, FLAW_NONE, 1'b0);
    run_phase(5);

    // Every limit at zero, then every limit at its maximum.
    load_limits('0, '0, '0);
    run_phase(25);
    load_limits('1, '1, '1);
    run_phase(20);

    // Random limits, then tiny ones together with a write to the spare index,
    // which must change nothing.
    load_limits(TICK_W'($urandom), TICK_W'($urandom_range(0, 5000)),
                TICK_W'($urandom_range(0, 200000)));
    run_phase(25);
    load_limits(TICK_W'(1), TICK_W'(1), TICK_W'($urandom_range(0, 100)));
    write_reg(REG_SPARE, TICK_W'($urandom));
    run_phase(25);

    drain_framer();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
